FILE: sv/psll_pkg.sv
// Shared types and codes for the pooled singly linked list.
package psll_pkg;

    localparam int POOL_SIZE_DEF = 64;
    localparam int NODE_W        = 6;
    localparam int LINK_W        = 7;
    localparam logic [LINK_W-1:0] NULL_LINK = '1;

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_INS   = 3'd1;
    localparam logic [2:0] OP_DELA  = 3'd2;
    localparam logic [2:0] OP_DELH  = 3'd3;
    localparam logic [2:0] OP_WALK  = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_BADIDX = 3'd2;
    localparam logic [2:0] ST_NODEL  = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    localparam logic [3:0] ACT_NONE      = 4'd0;
    localparam logic [3:0] ACT_STATUS    = 4'd1;
    localparam logic [3:0] ACT_PUSH      = 4'd2;
    localparam logic [3:0] ACT_INS_NEW   = 4'd3;
    localparam logic [3:0] ACT_INS_LINK  = 4'd4;
    localparam logic [3:0] ACT_DEL_RD    = 4'd5;
    localparam logic [3:0] ACT_DEL_AFTER = 4'd6;
    localparam logic [3:0] ACT_DEL_HEAD  = 4'd7;
    localparam logic [3:0] ACT_WALK      = 4'd8;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [31:0] value;
        logic [NODE_W-1:0] node_index;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [NODE_W-1:0] out_node;
        logic [2:0]        status;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       rd_follow;
        logic [3:0] act;
        logic [2:0] status;
    } ctl_t;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       idx_ok;
        logic       link_ok;
        logic       head_ok;
        logic       walk_last;
    } sts_t;

endpackage

FILE: sv/psll_ctrl.sv
// Sequencing state machine for the pooled singly linked list.
module psll_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  psll_pkg::sts_t sts,
    output psll_pkg::ctl_t ctl,
    output logic           busy
);
    import psll_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_INS2 = 3'd2;
    localparam logic [2:0] S_DEL2 = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        ctl.load      = 1'b0;
        ctl.rd_follow = 1'b0;
        ctl.act       = ACT_NONE;
        ctl.status    = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (sts.op)
                    OP_PUSH:
                    begin
                        if (sts.full)
                        begin
                            ctl.act    = ACT_STATUS;
                            ctl.status = ST_FULL;
                        end
                        else
                        begin
                            ctl.act = ACT_PUSH;
                        end
                    end
                    OP_INS:
                    begin
                        if (sts.full)
                        begin
                            ctl.act    = ACT_STATUS;
                            ctl.status = ST_FULL;
                        end
                        else if (!sts.idx_ok)
                        begin
                            ctl.act    = ACT_STATUS;
                            ctl.status = ST_BADIDX;
                        end
                        else
                        begin
                            ctl.act    = ACT_INS_NEW;
                            state_next = S_INS2;
                        end
                    end
                    OP_DELA:
                    begin
                        if (!sts.idx_ok)
                        begin
                            ctl.act    = ACT_STATUS;
                            ctl.status = ST_BADIDX;
                        end
                        else if (!sts.link_ok)
                        begin
                            ctl.act    = ACT_STATUS;
                            ctl.status = ST_NODEL;
                        end
                        else
                        begin
                            ctl.act       = ACT_DEL_RD;
                            ctl.rd_follow = 1'b1;
                            state_next    = S_DEL2;
                        end
                    end
                    OP_DELH:
                    begin
                        if (!sts.head_ok)
                        begin
                            ctl.act    = ACT_STATUS;
                            ctl.status = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.act = ACT_DEL_HEAD;
                        end
                    end
                    OP_WALK:
                    begin
                        if (!sts.head_ok)
                        begin
                            ctl.act    = ACT_STATUS;
                            ctl.status = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.act       = ACT_WALK;
                            ctl.rd_follow = 1'b1;
                            if (!sts.walk_last)
                                state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        ctl.act    = ACT_STATUS;
                        ctl.status = ST_OK;
                    end
                endcase
            end
            S_INS2:
            begin
                ctl.act    = ACT_INS_LINK;
                state_next = S_IDLE;
            end
            S_DEL2:
            begin
                ctl.act    = ACT_DEL_AFTER;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                ctl.act       = ACT_WALK;
                ctl.rd_follow = 1'b1;
                if (sts.walk_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/psll_dpath.sv
// Node pool memories, list pointers and result register.
module psll_dpath #(
    parameter int POOL_SIZE = psll_pkg::POOL_SIZE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  psll_pkg::req_t req,
    input  psll_pkg::ctl_t ctl,
    output psll_pkg::sts_t sts,
    output logic           rsp_valid,
    output psll_pkg::rsp_t rsp
);
    import psll_pkg::*;

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    logic signed [31:0] val_mem [POOL_SIZE];
    logic [LINK_W-1:0]  lnk_mem [POOL_SIZE];

    logic [2:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [NODE_W-1:0]  k_reg;
    logic [LINK_W-1:0]  head_reg;
    logic [LINK_W-1:0]  alloc_reg;
    logic [NODE_W-1:0]  cur_reg;
    logic [AW-1:0]      cnt_reg;
    logic [NODE_W-1:0]  victim_reg;
    logic [LINK_W-1:0]  rd_link_reg;
    logic signed [31:0] rd_value_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic [AW-1:0]      start_addr;
    logic [AW-1:0]      rd_addr;
    logic               lk_we;
    logic [AW-1:0]      lk_waddr;
    logic [LINK_W-1:0]  lk_wdata;
    logic               vl_we;

    assign sts.op        = op_reg;
    assign sts.full      = (alloc_reg == LINK_W'(POOL_SIZE));
    assign sts.idx_ok    = ({1'b0, k_reg} < alloc_reg);
    assign sts.link_ok   = (rd_link_reg < alloc_reg);
    assign sts.head_ok   = (head_reg < alloc_reg);
    assign sts.walk_last = !sts.link_ok || (cnt_reg == AW'(POOL_SIZE - 1));

    assign start_addr = (req.op == OP_INS || req.op == OP_DELA) ?
                        req.node_index[AW-1:0] : head_reg[AW-1:0];
    assign rd_addr    = ctl.rd_follow ? rd_link_reg[AW-1:0] : start_addr;

    always_comb
    begin
        lk_we          = 1'b0;
        lk_waddr       = alloc_reg[AW-1:0];
        lk_wdata       = head_reg;
        vl_we          = 1'b0;
        rsp_valid_next = 1'b0;
        rsp_next       = '0;
        case (ctl.act)
            ACT_STATUS:
            begin
                rsp_valid_next = 1'b1;
                rsp_next.status = ctl.status;
                rsp_next.last   = 1'b1;
            end
            ACT_PUSH:
            begin
                lk_we             = 1'b1;
                vl_we             = 1'b1;
                rsp_valid_next    = 1'b1;
                rsp_next.out_node = alloc_reg[NODE_W-1:0];
                rsp_next.last     = 1'b1;
            end
            ACT_INS_NEW:
            begin
                lk_we    = 1'b1;
                vl_we    = 1'b1;
                lk_wdata = rd_link_reg;
            end
            ACT_INS_LINK:
            begin
                lk_we             = 1'b1;
                lk_waddr          = k_reg[AW-1:0];
                lk_wdata          = alloc_reg;
                rsp_valid_next    = 1'b1;
                rsp_next.out_node = alloc_reg[NODE_W-1:0];
                rsp_next.last     = 1'b1;
            end
            ACT_DEL_AFTER:
            begin
                lk_we             = 1'b1;
                lk_waddr          = k_reg[AW-1:0];
                lk_wdata          = rd_link_reg;
                rsp_valid_next    = 1'b1;
                rsp_next.out_node = victim_reg;
                rsp_next.last     = 1'b1;
            end
            ACT_DEL_HEAD:
            begin
                rsp_valid_next    = 1'b1;
                rsp_next.out_node = head_reg[NODE_W-1:0];
                rsp_next.last     = 1'b1;
            end
            ACT_WALK:
            begin
                rsp_valid_next     = 1'b1;
                rsp_next.out_value = rd_value_reg;
                rsp_next.out_node  = cur_reg;
                rsp_next.last      = sts.walk_last;
            end
            default:
            begin
                lk_we = 1'b0;
            end
        endcase
    end

    // pool memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (lk_we)
            lnk_mem[lk_waddr] <= lk_wdata;
        if (vl_we)
            val_mem[alloc_reg[AW-1:0]] <= val_reg;
        rd_link_reg  <= lnk_mem[rd_addr];
        rd_value_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (ctl.load)
        begin
            op_reg  <= req.op;
            val_reg <= req.value;
            k_reg   <= req.node_index;
            cur_reg <= head_reg[NODE_W-1:0];
            cnt_reg <= '0;
        end
        else if (ctl.act == ACT_WALK)
        begin
            cur_reg <= rd_link_reg[NODE_W-1:0];
            cnt_reg <= cnt_reg + AW'(1);
        end
        if (ctl.act == ACT_DEL_RD)
            victim_reg <= rd_link_reg[NODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NULL_LINK;
            alloc_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (ctl.act == ACT_PUSH)
                head_reg <= alloc_reg;
            else if (ctl.act == ACT_DEL_HEAD)
                head_reg <= rd_link_reg;
            if (ctl.act == ACT_PUSH || ctl.act == ACT_INS_LINK)
                alloc_reg <= alloc_reg + LINK_W'(1);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/pooled_singly_linked_list.sv
// Top level of the pooled singly linked list.
//
//  channel   handshake                 payload
//  --------  ------------------------  -----------------------------------
//  command   start, busy               cmd  (op, value, node_index)
//  result    rsp_valid                 rsp  (out_value, out_node, status, last)
//
// Push, delete head and any rejected command pass through one execute state
// before the next transfer. Insert and delete after node add a second state
// (the link memory is read before it is written). A walk does one link memory
// read per node. Reset clears the head pointer and allocation count; the pool
// memories are not cleared. Results cannot be stalled.
module pooled_singly_linked_list #(
    parameter int POOL_SIZE = psll_pkg::POOL_SIZE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  psll_pkg::req_t cmd,
    output logic           rsp_valid,
    output psll_pkg::rsp_t rsp
);
    import psll_pkg::*;

    ctl_t ctl;
    sts_t sts;

    psll_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    psll_dpath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.last)
        else $error("error status on a non-final result");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last |-> !busy)
        else $error("controller still busy after final result");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> busy)
        else $error("walk result without busy controller");

endmodule
